@@ design/rdm_fcac_pkg.sv @@
`default_nettype none

package rdm_fcac_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 9;
    localparam int unsigned SUM_W    = 16;
    localparam int unsigned UID_W    = 48;
    localparam int unsigned STATUS_W = 3;

    // result word: status, computed sum, received sum, zero fill to whole bytes
    localparam int unsigned RES_W    = STATUS_W + 2 * SUM_W;
    localparam int unsigned M_DATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] ALL_ONES_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] MIN_LENGTH    = 8'd9;

    localparam logic [POS_W-1:0] POS_LENGTH    = 9'd2;
    localparam logic [POS_W-1:0] POS_UID_FIRST = 9'd3;
    localparam logic [POS_W-1:0] POS_UID_LAST  = 9'd8;

    typedef enum logic [STATUS_W-1:0] {
        ST_PERSONAL      = 3'd0,
        ST_BROADCAST     = 3'd1,
        ST_CSUM_ERR      = 3'd2,
        ST_ADDR_MISMATCH = 3'd3,
        ST_BAD_LENGTH    = 3'd4
    } status_t;

    // uid byte compared at packet position pos (3..8), most significant first
    function automatic logic [BYTE_W-1:0] uid_byte(input logic [UID_W-1:0] uid,
                                                   input logic [POS_W-1:0] pos);
        logic [2:0] idx;
        logic [BYTE_W-1:0] res;
        idx = 3'(pos - POS_UID_FIRST);
        unique case (idx)
            3'd0:    res = uid[47:40];
            3'd1:    res = uid[39:32];
            3'd2:    res = uid[31:24];
            3'd3:    res = uid[23:16];
            3'd4:    res = uid[15:8];
            3'd5:    res = uid[7:0];
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/rdm_frame_checksum_address_check_core.sv @@
// channel   dir  signals                        contents
// s_        in   s_tvalid s_tready s_tdata[7:0]  tdata: rx_byte; tuser[0]: frame_start
//                s_tuser[0:0]
// m_        out  m_tvalid m_tready m_tdata[39:0] tdata: status, computed_sum, received_sum
// cfg_      in   cfg_we cfg_wdata[47:0]          device_uid, written when cfg_we is high
//
// one word per cycle while the output is not stalled: a word is held in the input register,
// and its result is loaded from there into the output register
// the input register moves on whenever the output register is empty or being taken,
// so a held result stalls s_tready only when both registers are full
// aresetn is synchronous, active low; it resets the frame state and clears device_uid
// and both valid flags

`default_nettype none

module rdm_frame_checksum_address_check_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [rdm_fcac_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]                          s_tuser,   // [0] frame_start

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [2:0] status, [18:3] computed_sum, [34:19] received_sum, [39:35] zero
    output logic [rdm_fcac_pkg::M_DATA_W-1:0]        m_tdata,

    input  wire logic                                cfg_we,
    input  wire logic [rdm_fcac_pkg::UID_W-1:0]      cfg_wdata
);

    localparam int unsigned BYTE_W = rdm_fcac_pkg::BYTE_W;
    localparam int unsigned POS_W  = rdm_fcac_pkg::POS_W;
    localparam int unsigned SUM_W  = rdm_fcac_pkg::SUM_W;
    localparam int unsigned UID_W  = rdm_fcac_pkg::UID_W;
    localparam int unsigned RES_W  = rdm_fcac_pkg::RES_W;
    localparam int unsigned M_DATA_W = rdm_fcac_pkg::M_DATA_W;

    // configuration
    logic [UID_W-1:0] device_uid_reg;

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_start_reg;

    // frame state
    logic              in_frame_reg, in_frame_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] len_reg, len_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0] csum_hi_reg, csum_hi_next;
    logic              ones_reg, ones_next;
    logic              match_reg, match_next;

    // output register
    logic                m_valid_reg;
    logic [RES_W-1:0]    m_data_reg;

    logic                  advance;
    logic                  res_valid;
    rdm_fcac_pkg::status_t res_status;
    logic [SUM_W-1:0]      res_computed;
    logic [SUM_W-1:0]      res_received;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - RES_W){1'b0}}, m_data_reg};

    always_comb begin
        logic [POS_W-1:0]  cur_pos;
        logic [SUM_W-1:0]  cur_sum;
        logic [BYTE_W-1:0] cur_hi;
        logic [SUM_W-1:0]  rx_sum;

        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        sum_next      = sum_reg;
        csum_hi_next  = csum_hi_reg;
        ones_next     = ones_reg;
        match_next    = match_reg;
        res_valid     = 1'b0;
        res_status    = rdm_fcac_pkg::ST_PERSONAL;
        res_computed  = '0;
        res_received  = '0;

        // a start word reopens the frame before it is processed as byte 0
        if (in_start_reg) begin
            in_frame_next = 1'b1;
            len_next      = '0;
            ones_next     = 1'b1;
            match_next    = 1'b1;
        end
        cur_pos = in_start_reg ? '0 : pos_reg;
        cur_sum = in_start_reg ? '0 : sum_reg;
        cur_hi  = in_start_reg ? '0 : csum_hi_reg;
        sum_next     = cur_sum;
        csum_hi_next = cur_hi;
        pos_next     = cur_pos;
        rx_sum       = {cur_hi, in_byte_reg};

        if (in_start_reg || in_frame_reg) begin
            if (cur_pos == rdm_fcac_pkg::POS_LENGTH && in_byte_reg < rdm_fcac_pkg::MIN_LENGTH) begin
                len_next      = in_byte_reg;
                in_frame_next = 1'b0;
                res_valid     = 1'b1;
                res_status    = rdm_fcac_pkg::ST_BAD_LENGTH;
            end else begin
                if (cur_pos == rdm_fcac_pkg::POS_LENGTH) begin
                    len_next = in_byte_reg;
                end
                if (cur_pos >= rdm_fcac_pkg::POS_UID_FIRST &&
                    cur_pos <= rdm_fcac_pkg::POS_UID_LAST) begin
                    if (in_byte_reg != rdm_fcac_pkg::ALL_ONES_BYTE) begin
                        ones_next = 1'b0;
                    end
                    if (in_byte_reg != rdm_fcac_pkg::uid_byte(device_uid_reg, cur_pos)) begin
                        match_next = 1'b0;
                    end
                end
                if (cur_pos < rdm_fcac_pkg::POS_UID_FIRST ||
                    cur_pos < {1'b0, len_next}) begin
                    sum_next = cur_sum + {{(SUM_W - BYTE_W){1'b0}}, in_byte_reg};
                    pos_next = cur_pos + 1'b1;
                end else if (cur_pos == {1'b0, len_next}) begin
                    csum_hi_next = in_byte_reg;
                    pos_next     = cur_pos + 1'b1;
                end else begin
                    // second checksum byte closes the frame
                    in_frame_next = 1'b0;
                    pos_next      = '0;
                    res_valid     = 1'b1;
                    res_computed  = cur_sum;
                    res_received  = rx_sum;
                    priority if (rx_sum != cur_sum) begin
                        res_status = rdm_fcac_pkg::ST_CSUM_ERR;
                    end else if (ones_next) begin
                        res_status = rdm_fcac_pkg::ST_BROADCAST;
                    end else if (match_next) begin
                        res_status = rdm_fcac_pkg::ST_PERSONAL;
                    end else begin
                        res_status = rdm_fcac_pkg::ST_ADDR_MISMATCH;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_uid_reg <= '0;
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            in_frame_reg   <= 1'b0;
            pos_reg        <= '0;
            len_reg        <= '0;
            sum_reg        <= '0;
            csum_hi_reg    <= '0;
            ones_reg       <= 1'b1;
            match_reg      <= 1'b1;
        end else begin
            if (cfg_we) begin
                device_uid_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance && (in_start_reg || in_frame_reg)) begin
                in_frame_reg <= in_frame_next;
                pos_reg      <= pos_next;
                len_reg      <= len_next;
                sum_reg      <= sum_next;
                csum_hi_reg  <= csum_hi_next;
                ones_reg     <= ones_next;
                match_reg    <= match_next;
            end
            if (advance && res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (advance && res_valid) begin
            m_data_reg <= {res_received, res_computed, res_status};
        end
    end

`ifndef SYNTH
    // a malformed length carries no sums
    a_bad_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] == rdm_fcac_pkg::ST_BAD_LENGTH |->
            m_tdata[34:3] == '0)
        else $error("malformed length result with nonzero sums");

    // accepted packets must have matching checksums
    a_accept_sum_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == rdm_fcac_pkg::ST_PERSONAL ||
                     m_tdata[2:0] == rdm_fcac_pkg::ST_BROADCAST) |->
            m_tdata[18:3] == m_tdata[34:19])
        else $error("accepted packet with checksum mismatch");

    // every reported status closes the frame
    a_result_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_valid |=> !in_frame_reg)
        else $error("frame still open after a result");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !advance)
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ tb/sv/rdm_frame_checksum_address_check_core_tb.sv @@
`default_nettype none

module rdm_frame_checksum_address_check_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BYTE_W   = rdm_fcac_pkg::BYTE_W;
    localparam int unsigned POS_W    = rdm_fcac_pkg::POS_W;
    localparam int unsigned SUM_W    = rdm_fcac_pkg::SUM_W;
    localparam int unsigned UID_W    = rdm_fcac_pkg::UID_W;
    localparam int unsigned M_DATA_W = rdm_fcac_pkg::M_DATA_W;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } rx_word_t;

    typedef struct {
        rdm_fcac_pkg::status_t status;
        logic [SUM_W-1:0]      computed;
        logic [SUM_W-1:0]      received;
    } packet_verdict_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata   = '0;   // [7:0] rx_byte
    logic [0:0]           s_tuser   = '0;   // [0] frame_start
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // [2:0] status, [18:3] computed_sum, [34:19] received_sum, [39:35] zero
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [UID_W-1:0]     cfg_wdata = '0;

    rx_word_t        pending_words[$];
    packet_verdict_t expected_verdicts[$];
    int              err_count = 0;
    bit              steady    = 1'b0;

    // predictor copy of the frame state
    logic [UID_W-1:0]  own_uid    = '0;
    logic              fr_open    = 1'b0;
    logic [POS_W-1:0]  fr_pos     = '0;
    logic [BYTE_W-1:0] fr_len     = '0;
    logic [SUM_W-1:0]  fr_sum     = '0;
    logic [BYTE_W-1:0] fr_csum_hi = '0;
    logic              fr_bcast   = 1'b1;
    logic              fr_ours    = 1'b1;

    rdm_frame_checksum_address_check_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic void predict_word(input logic [BYTE_W-1:0] b, input logic start);
        logic [BYTE_W-1:0]     ub;
        logic [SUM_W-1:0]      rx;
        rdm_fcac_pkg::status_t st;
        if (start) begin
            fr_open    = 1'b1;
            fr_pos     = '0;
            fr_len     = '0;
            fr_sum     = '0;
            fr_csum_hi = '0;
            fr_bcast   = 1'b1;
            fr_ours    = 1'b1;
        end else if (!fr_open) begin
            return;
        end
        if (fr_pos == rdm_fcac_pkg::POS_LENGTH) begin
            fr_len = b;
            if (b < rdm_fcac_pkg::MIN_LENGTH) begin
                fr_open = 1'b0;
                expected_verdicts.push_back('{rdm_fcac_pkg::ST_BAD_LENGTH, '0, '0});
                return;
            end
        end
        if (fr_pos >= rdm_fcac_pkg::POS_UID_FIRST && fr_pos <= rdm_fcac_pkg::POS_UID_LAST) begin
            ub = own_uid[8 * (int'(rdm_fcac_pkg::POS_UID_LAST) - int'(fr_pos)) +: 8];
            if (b != rdm_fcac_pkg::ALL_ONES_BYTE) fr_bcast = 1'b0;
            if (b != ub) fr_ours = 1'b0;
        end
        if (fr_pos < rdm_fcac_pkg::POS_UID_FIRST || fr_pos < fr_len) begin
            fr_sum = fr_sum + b;
        end else if (fr_pos == fr_len) begin
            fr_csum_hi = b;
        end else begin
            rx = {fr_csum_hi, b};
            if (rx != fr_sum)  st = rdm_fcac_pkg::ST_CSUM_ERR;
            else if (fr_bcast) st = rdm_fcac_pkg::ST_BROADCAST;
            else if (fr_ours)  st = rdm_fcac_pkg::ST_PERSONAL;
            else               st = rdm_fcac_pkg::ST_ADDR_MISMATCH;
            fr_open = 1'b0;
            fr_pos  = '0;
            expected_verdicts.push_back('{st, fr_sum, rx});
            return;
        end
        fr_pos = fr_pos + 1'b1;
    endfunction

    // source side: one word held until taken
    always @(posedge aclk) begin : src_drive
        rx_word_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_word(s_tdata, s_tuser[0]);
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() > 0 && (steady || $urandom_range(99) >= 11)) begin
                    nxt = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin : res_check
        packet_verdict_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result with none expected", int'(m_tdata), 0);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_tdata[2:0] != want.status)
                        report_mismatch("status", int'(m_tdata[2:0]), int'(want.status));
                    if (m_tdata[18:3] != want.computed)
                        report_mismatch("computed_sum", int'(m_tdata[18:3]),
                                        int'(want.computed));
                    if (m_tdata[34:19] != want.received)
                        report_mismatch("received_sum", int'(m_tdata[34:19]),
                                        int'(want.received));
                end
            end
            m_tready <= steady || ($urandom_range(99) >= 11);
        end
    end

    task automatic push_word(input logic [BYTE_W-1:0] b, input logic start);
        pending_words.push_back('{data: b, start: start});
    endtask

    task automatic queue_packet(input logic [BYTE_W-1:0] len, input logic [UID_W-1:0] dest,
                                input bit corrupt);
        logic [SUM_W-1:0]  sum;
        logic [BYTE_W-1:0] b;
        sum = '0;
        for (int p = 0; p < len; p++) begin
            if (p == rdm_fcac_pkg::POS_LENGTH)
                b = len;
            else if (p >= rdm_fcac_pkg::POS_UID_FIRST && p <= rdm_fcac_pkg::POS_UID_LAST)
                b = dest[8 * (int'(rdm_fcac_pkg::POS_UID_LAST) - p) +: 8];
            else
                b = 8'($urandom);
            push_word(b, p == 0);
            sum = sum + b;
        end
        if (corrupt)
            sum = sum ^ 16'($urandom_range(65535, 1));
        push_word(sum[15:8], 1'b0);
        push_word(sum[7:0], 1'b0);
    endtask

    // mostly well-formed packets, the rest broken frames and line noise
    task automatic queue_traffic(input int n_words);
        int               added;
        int               kind;
        int               n;
        logic [UID_W-1:0] dest;
        logic [BYTE_W-1:0] len;
        added = 0;
        while (added < n_words) begin
            kind = $urandom_range(99);
            if (kind < 72) begin
                n = $urandom_range(99);
                if (n < 30)      dest = '1;
                else if (n < 55) dest = own_uid;
                else if (n < 80) dest = own_uid ^ (48'($urandom_range(255, 1))
                                                   << (8 * $urandom_range(5)));
                else             dest = {16'($urandom), 32'($urandom)};
                len = ($urandom_range(99) < 4) ? 8'($urandom_range(255, 25))
                                               : 8'($urandom_range(24, 9));
                queue_packet(len, dest, $urandom_range(99) < 15);
                added += len + 2;
            end else if (kind < 80) begin
                // length too short for the header
                push_word(8'($urandom), 1'b1);
                push_word(8'($urandom), 1'b0);
                push_word(8'($urandom_range(8)), 1'b0);
                added += 3;
            end else if (kind < 88) begin
                // often cut short before the checksum, the next start abandons it
                n = $urandom_range(12, 1);
                push_word(8'($urandom), 1'b1);
                for (int i = 1; i < n; i++)
                    push_word((i == rdm_fcac_pkg::POS_LENGTH) ? 8'($urandom_range(255, 9))
                                                              : 8'($urandom),
                              1'b0);
                added += n;
            end else begin
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++)
                    push_word(8'($urandom), $urandom_range(3) == 0);
                added += n;
            end
        end
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        @(negedge aclk);
        while ((pending_words.size() > 0 || s_tvalid || expected_verdicts.size() > 0)
               && guard < 5000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (8) @(negedge aclk);
        while (expected_verdicts.size() > 0) begin
            report_mismatch("missing result, status",
                            -1, int'(expected_verdicts[0].status));
            void'(expected_verdicts.pop_front());
        end
    endtask

    task automatic write_uid(input logic [UID_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        own_uid = v;
        @(negedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: uid still at its reset value of zero
        push_word(8'hA5, 1'b0);            // stray word, no frame open
        queue_packet(8'd9, '0, 1'b0);      // shortest valid packet, addressed to us
        push_word(8'hCC, 1'b1);            // frame restarted before it finishes
        push_word(8'h01, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(8'hCC, 1'b1);            // length one below the minimum
        push_word(8'h00, 1'b0);
        push_word(8'h08, 1'b0);
        push_word(8'h00, 1'b0);            // ignored after the frame closed
        push_word(8'hCC, 1'b1);            // zero length
        push_word(8'hFF, 1'b0);
        push_word(8'h00, 1'b0);
        wait_drain();

        // uid all ones: broadcast must still win
        write_uid('1);
        queue_traffic(350);
        wait_drain();

        write_uid({16'($urandom), 32'($urandom)});
        steady = 1'b1;
        queue_packet(8'd255, own_uid, 1'b0);
        queue_traffic(400);
        wait_drain();
        steady = 1'b0;

        write_uid({16'($urandom), 32'($urandom)});
        queue_traffic(500);
        wait_drain();

        write_uid('0);
        queue_traffic(300);
        wait_drain();

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
